// ===== hdl/mie_pkg.sv =====
// shared types and constants for the modular inverse block
`timescale 1ns / 1ps

package mie_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FIELD_W   = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] modulus;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        logic               not_coprime;
    } t_out;

endpackage

// ===== hdl/mie_divstep.sv =====
// bit-serial euclid step: restoring division with a running quotient times coefficient product
`timescale 1ns / 1ps

module mie_divstep #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    input  logic [WIDTH:0]   i_mult,
    output logic             o_done,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH:0]   o_prod
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_div;
    logic [WIDTH:0]   r_mult;
    logic [WIDTH:0]   r_acc;

    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;

    // shift in the next dividend bit and try to take the divisor out
    assign w_trial = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = !w_diff[WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(WIDTH);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
            r_mult <= i_mult;
            r_acc  <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
            // horner form of quotient times coefficient, msb first
            r_acc <= {r_acc[WIDTH-1:0], 1'b0} + (w_ge ? r_mult : '0);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_acc;

endmodule

// ===== hdl/modular_inverse_ext_euclid.sv =====
// modular inverse by the extended euclidean algorithm, top level
//
//  port group   dir  payload      handshake
//  input item   in   mie_pkg::t_in   i_valid / o_stall
//  result item  out  mie_pkg::t_out  o_valid / i_stall
//
// each euclid step runs S_CHECK, S_START, the bit-serial divider in S_DIV, and
// S_UPDATE; a last S_CHECK and S_DONE wrap up each item
// reset is synchronous, active low, and clears the controller and output valid
// the input is stalled while an item is in work; a waiting result does not
// block the next item until that item is ready to deliver
`timescale 1ns / 1ps

module modular_inverse_ext_euclid #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mie_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output mie_pkg::t_out o_data
);

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_START, S_DIV, S_UPDATE, S_DONE} t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH:0]   r_sp;
    logic [WIDTH:0]   r_sc;
    logic             r_idx;
    logic             r_valid;
    mie_pkg::t_out    r_out;

    logic             w_start;
    logic             w_done;
    logic [WIDTH-1:0] w_rem;
    logic [WIDTH:0]   w_prod;
    logic [WIDTH:0]   w_red;
    logic [WIDTH:0]   w_inv;

    assign w_start = (r_state == S_START);

    mie_divstep #(.WIDTH(WIDTH)) u_divstep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .i_mult     (r_sc),
        .o_done     (w_done),
        .o_rem      (w_rem),
        .o_prod     (w_prod)
    );

    // coefficient magnitude never exceeds the modulus, so one subtract reduces it
    always_comb begin
        if (r_m == '0) begin
            w_red = '0;
        end else if (r_sp >= {1'b0, r_m}) begin
            w_red = r_sp - {1'b0, r_m};
        end else begin
            w_red = r_sp;
        end
        // odd index means the coefficient is non-positive
        if (r_idx && w_red != '0) begin
            w_inv = {1'b0, r_m} - w_red;
        end else begin
            w_inv = w_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall && r_state != S_DONE) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_m     <= WIDTH'(i_data.modulus);
                        r_a     <= WIDTH'(i_data.value);
                        r_b     <= WIDTH'(i_data.modulus);
                        r_sp    <= (WIDTH+1)'(1);
                        r_sc    <= '0;
                        r_idx   <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= (r_b == '0) ? S_DONE : S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_done) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_a     <= r_b;
                    r_b     <= w_rem;
                    r_sp    <= r_sc;
                    r_sc    <= r_sp + w_prod;
                    r_idx   <= !r_idx;
                    r_state <= S_CHECK;
                end
                S_DONE: begin
                    if (!r_valid || !i_stall) begin
                        r_out.inverse     <= mie_pkg::FIELD_W'(w_inv[WIDTH-1:0]);
                        r_out.not_coprime <= (r_a != WIDTH'(1));
                        r_valid           <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input not stalled while an item is in work");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_DIV))
        else $error("divider finished outside a division");

    a_coef_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_m != '0) |-> (r_sp <= {1'b0, r_m}))
        else $error("coefficient magnitude above modulus");

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_valid) |=> (r_valid && r_state == S_IDLE))
        else $error("finished item not delivered to output register");

endmodule

// ===== verif/mie_checker.sv =====
// checker for the modular inverse block: predicts each result and compares it
`timescale 1ns / 1ps

module mie_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall_in,
    input  mie_pkg::t_in  i_data,
    input  logic          i_ovalid,
    input  logic          i_stall_out,
    input  mie_pkg::t_out i_odata,
    output int            o_fail_count,
    output int            o_pending
);

    mie_pkg::t_out inverse_queue[$];

    // coefficients kept as magnitude plus sign parity, as they alternate
    function automatic mie_pkg::t_out predict_inverse(mie_pkg::t_in item);
        logic [63:0] m;
        logic [63:0] r_prev;
        logic [63:0] r_cur;
        logic [63:0] r_next;
        logic [63:0] s_prev;
        logic [63:0] s_cur;
        logic [63:0] s_next;
        logic [63:0] q;
        logic [63:0] red;
        logic        odd;
        mie_pkg::t_out res;
        m = {32'd0, item.modulus};
        r_prev = {32'd0, item.value};
        r_cur = m;
        s_prev = 64'd1;
        s_cur = 64'd0;
        odd = 1'b0;
        while (r_cur != 0) begin
            q = r_prev / r_cur;
            r_next = r_prev - q * r_cur;
            s_next = s_prev + q * s_cur;
            r_prev = r_cur;
            r_cur = r_next;
            s_prev = s_cur;
            s_cur = s_next;
            odd = ~odd;
        end
        if (m == 0) begin
            red = 64'd0;
        end else begin
            red = s_prev % m;
            if (odd && red != 0) red = m - red;
        end
        res.inverse = red[31:0];
        res.not_coprime = (r_prev != 64'd1);
        return res;
    endfunction

    assign o_pending = inverse_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        mie_pkg::t_out want;
        int n_fail;
        n_fail = o_fail_count;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) inverse_queue.push_back(predict_inverse(i_data));
            if (i_ovalid && !i_stall_out) begin
                if (inverse_queue.size() == 0) begin
                    $error("result item with nothing expected");
                    n_fail = n_fail + 1;
                end else begin
                    want = inverse_queue.pop_front();
                    if (want.inverse !== i_odata.inverse) begin
                        $error("inverse: expected %0d, got %0d", want.inverse,
                               i_odata.inverse);
                        n_fail = n_fail + 1;
                    end
                    if (want.not_coprime !== i_odata.not_coprime) begin
                        $error("not_coprime: expected %0b, got %0b", want.not_coprime,
                               i_odata.not_coprime);
                        n_fail = n_fail + 1;
                    end
                end
            end
        end
        o_fail_count <= n_fail;
    end
endmodule

// ===== verif/tb_top.sv =====
// testbench top for the modular inverse block: stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    mie_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    mie_pkg::t_out o_data;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;

    modular_inverse_ext_euclid dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    mie_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_data(i_data), .i_ovalid(o_valid), .i_stall_out(i_stall), .i_odata(o_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // fibonacci neighbors give the longest euclid chains
    function automatic logic [31:0] fib(int n);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        a = 0;
        b = 1;
        repeat (n) begin
            t = a + b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [31:0] rand_field();
        case ($urandom_range(4))
            0: return $urandom_range(20);
            1: return 32'hFFFF_FFFF - $urandom_range(20);
            2: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after acceptance until the next item or an idle cycle
    task automatic send_item(logic [31:0] v, logic [31:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data.value <= v;
        i_data.modulus <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] m;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 33;
        recv_idle_pct = 47;
        send_item(32'd3, 32'd7);
        send_item(32'd0, 32'd13);
        send_item(32'd0, 32'd1);
        send_item(32'd5, 32'd1);
        send_item(32'd1, 32'd0);
        send_item(32'd6, 32'd0);
        send_item(32'd0, 32'd0);
        send_item(32'd4, 32'd6);
        send_item(32'd100, 32'd7);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd1, 32'hFFFF_FFFF);
        send_item(32'd65537, 32'hFFFF_FFFE);
        send_item(fib(46), fib(47));
        send_item(fib(47), fib(46));
        send_item(32'hAAAA_AAAA, 32'h5555_5555);
        send_item(32'h5555_5555, 32'hAAAA_AAAB);
        send_item(32'd2, 32'd2);

        // hold off until every result is back
        drain();
        for (int k = 0; k < 400; k++) begin
            if (k == 140) begin
                send_idle_pct = 47;
                recv_idle_pct = 33;
            end
            if (k == 270) begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            m = rand_field();
            if ($urandom_range(9) == 0) m = $urandom_range(2);
            send_item(rand_field(), m);
        end
        drain();
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
